@@ rtl/nlcd_pkg.sv @@
package nlcd_pkg;

	localparam int unsigned VALUE_W   = 16;
	localparam int unsigned DIGIT_W   = 4;
	localparam int unsigned DIGITS    = 4;
	localparam int unsigned BCD_W     = DIGIT_W * DIGITS;
	localparam int unsigned SEG_W     = 8;
	localparam int unsigned NUM_CELLS = VALUE_W;

	typedef logic [VALUE_W-1:0] value_t;
	typedef logic [BCD_W-1:0]   bcd_t;
	typedef logic [DIGIT_W-1:0] digit_t;
	typedef logic [SEG_W-1:0]   seg_t;

	// what one cell hands to the next
	typedef struct packed {
		logic   valid;
		bcd_t   bcd;
		value_t bits;
	} stage_t;

	typedef struct packed {
		seg_t first;
		seg_t second;
	} seg_pair_t;

	// one doubling step of the packed BCD accumulator, with the next binary bit
	// shifted in; carry out of the top digit is dropped
	function automatic bcd_t bcd_double(bcd_t acc, logic cin);
		bcd_t             res;
		logic             carry;
		logic [DIGIT_W:0] d;
		res   = '0;
		carry = cin;
		for (int k = 0; k < DIGITS; k++) begin
			d = {acc[k*DIGIT_W +: DIGIT_W], 1'b0} + {{DIGIT_W{1'b0}}, carry};
			if (d >= (DIGIT_W+1)'(10)) begin
				d     = d - (DIGIT_W+1)'(10);
				carry = 1'b1;
			end else begin
				carry = 1'b0;
			end
			res[k*DIGIT_W +: DIGIT_W] = d[DIGIT_W-1:0];
		end
		return res;
	endfunction

	function automatic seg_pair_t seg_lookup(digit_t d);
		seg_pair_t p;
		case (d)
			4'd0:    p = '{first: 8'hFC, second: 8'h28};
			4'd1:    p = '{first: 8'h60, second: 8'h20};
			4'd2:    p = '{first: 8'hDB, second: 8'h00};
			4'd3:    p = '{first: 8'hF3, second: 8'h00};
			4'd4:    p = '{first: 8'h67, second: 8'h00};
			4'd5:    p = '{first: 8'hB7, second: 8'h00};
			4'd6:    p = '{first: 8'hBF, second: 8'h00};
			4'd7:    p = '{first: 8'hE4, second: 8'h00};
			4'd8:    p = '{first: 8'hFF, second: 8'h00};
			default: p = '{first: 8'hF7, second: 8'h00};
		endcase
		return p;
	endfunction

endpackage

@@ rtl/nlcd_if.sv @@
interface nlcd_value_if;
	import nlcd_pkg::*;
	logic   valid;
	logic   ready;
	value_t value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

interface nlcd_seg_if;
	import nlcd_pkg::*;
	logic valid;
	logic ready;
	seg_t thousands_first_byte;
	seg_t thousands_second_byte;
	seg_t hundreds_first_byte;
	seg_t hundreds_second_byte;
	seg_t tens_first_byte;
	seg_t tens_second_byte;
	seg_t ones_first_byte;
	seg_t ones_second_byte;

	modport source (
		output valid,
		input  ready,
		output thousands_first_byte, output thousands_second_byte,
		output hundreds_first_byte,  output hundreds_second_byte,
		output tens_first_byte,      output tens_second_byte,
		output ones_first_byte,      output ones_second_byte
	);
	modport sink (
		input  valid,
		output ready,
		input  thousands_first_byte, input thousands_second_byte,
		input  hundreds_first_byte,  input hundreds_second_byte,
		input  tens_first_byte,      input tens_second_byte,
		input  ones_first_byte,      input ones_second_byte
	);
endinterface

@@ rtl/number_to_lcd_segments.sv @@
// Binary to four-digit LCD segment converter.
// value_ch (sink): a 16-bit unsigned value per transaction; it is shown modulo 10000.
// seg_ch (source): two segment bytes for each of thousands, hundreds, tens
// and ones. Leading zero digits come out as zero bytes; ones always shows.
// Both channels use valid/ready; a transaction moves when both are high.
// Conversion runs through a row of sixteen cells, one per input bit, each
// doubling the BCD accumulator and shifting in the next bit, followed by a
// registered table lookup and blanking stage.
// Throughput: one transaction per cycle unless seg_ch stalls; every cell is a stage.
// Stalls: each cell holds its transaction while the next one is full and
// stalled, so value_ch.ready drops only when all 17 stages are occupied and
// seg_ch.ready is low. Held outputs stay stable until taken.
// Reset (arst_n low) empties every stage; results in flight are lost.
module number_to_lcd_segments
	import nlcd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	nlcd_value_if.sink value_ch,
	nlcd_seg_if.source seg_ch
);

	stage_t st    [NUM_CELLS+1];
	logic   rdy   [NUM_CELLS+1];

	assign st[0]          = '{valid: value_ch.valid, bcd: '0, bits: value_ch.value};
	assign value_ch.ready = rdy[0];

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		nlcd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up       (st[i]),
			.up_ready (rdy[i]),
			.dn       (st[i+1]),
			.dn_ready (rdy[i+1])
		);
	end

	nlcd_seg_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.up       (st[NUM_CELLS]),
		.up_ready (rdy[NUM_CELLS]),
		.seg      (seg_ch)
	);

	// input can only back up when the whole row is full and the sink stalls
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		!value_ch.ready |-> (seg_ch.valid && !seg_ch.ready))
		else $error("input stalled while output not blocked");

	a_ones_shown: assert property (@(posedge clk) disable iff (!arst_n)
		seg_ch.valid |-> (seg_ch.ones_first_byte != '0))
		else $error("ones digit blanked");

	a_blank_order: assert property (@(posedge clk) disable iff (!arst_n)
		(seg_ch.valid && (seg_ch.thousands_first_byte != '0)) |->
		((seg_ch.hundreds_first_byte != '0) && (seg_ch.tens_first_byte != '0)))
		else $error("zero below a shown digit was blanked");

	a_tens_order: assert property (@(posedge clk) disable iff (!arst_n)
		(seg_ch.valid && (seg_ch.hundreds_first_byte != '0)) |->
		(seg_ch.tens_first_byte != '0))
		else $error("tens blanked below shown hundreds");

endmodule

@@ rtl/nlcd_cell.sv @@
module nlcd_cell
	import nlcd_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  stage_t up,
	output logic   up_ready,
	output stage_t dn,
	input  logic   dn_ready
);

	logic   valid_q;
	bcd_t   bcd_q;
	value_t bits_q;
	logic   adv;

	// a cell takes a new transaction when empty or when its own is moving on
	assign adv      = !valid_q || dn_ready;
	assign up_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= up.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && up.valid) begin
			bcd_q  <= bcd_double(up.bcd, up.bits[VALUE_W-1]);
			bits_q <= {up.bits[VALUE_W-2:0], 1'b0};
		end
	end

	assign dn = '{valid: valid_q, bcd: bcd_q, bits: bits_q};

endmodule

@@ rtl/nlcd_seg_out.sv @@
module nlcd_seg_out
	import nlcd_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  stage_t up,
	output logic   up_ready,
	nlcd_seg_if.source seg
);

	logic      valid_q;
	logic      adv;
	digit_t    d3, d2, d1, d0;
	logic      show3, show2, show1;
	seg_pair_t p3, p2, p1, p0;
	seg_pair_t p3_q, p2_q, p1_q, p0_q;

	assign adv      = !valid_q || seg.ready;
	assign up_ready = adv;

	assign d3 = up.bcd[4*DIGIT_W-1 -: DIGIT_W];
	assign d2 = up.bcd[3*DIGIT_W-1 -: DIGIT_W];
	assign d1 = up.bcd[2*DIGIT_W-1 -: DIGIT_W];
	assign d0 = up.bcd[DIGIT_W-1:0];

	// leading-zero blanking; the ones digit always shows
	assign show3 = (d3 != '0);
	assign show2 = show3 || (d2 != '0);
	assign show1 = show2 || (d1 != '0);

	always_comb begin
		p3 = show3 ? seg_lookup(d3) : '0;
		p2 = show2 ? seg_lookup(d2) : '0;
		p1 = show1 ? seg_lookup(d1) : '0;
		p0 = seg_lookup(d0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= up.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && up.valid) begin
			p3_q <= p3;
			p2_q <= p2;
			p1_q <= p1;
			p0_q <= p0;
		end
	end

	assign seg.valid                 = valid_q;
	assign seg.thousands_first_byte  = p3_q.first;
	assign seg.thousands_second_byte = p3_q.second;
	assign seg.hundreds_first_byte   = p2_q.first;
	assign seg.hundreds_second_byte  = p2_q.second;
	assign seg.tens_first_byte       = p1_q.first;
	assign seg.tens_second_byte      = p1_q.second;
	assign seg.ones_first_byte       = p0_q.first;
	assign seg.ones_second_byte      = p0_q.second;

endmodule

@@ bench/tb_number_to_lcd_segments.sv @@
`timescale 1ns / 100ps

module tb_number_to_lcd_segments;
	import nlcd_pkg::*;

	localparam int CLK_PERIOD     = 12;
	localparam int RESET_CYCLES   = 12;
	localparam int HOLD_CYCLES    = 80;
	localparam int SETTLE_CYCLES  = 40;
	localparam int REPORT_LIMIT   = 10;
	localparam int TIMEOUT_CYCLES = 300_000;

	// four digit positions, most significant first, each {first, second}
	typedef struct packed {
		seg_pair_t thousands;
		seg_pair_t hundreds;
		seg_pair_t tens;
		seg_pair_t ones;
	} lcd_frame_t;

	typedef struct packed {
		value_t      value;
		logic        typed;
		logic [63:0] frame;
	} directed_row_t;

	localparam logic [15:0] DIGIT_GLYPH [10] = '{
		16'hFC28, 16'h6020, 16'hDB00, 16'hF300, 16'h6700,
		16'hB700, 16'hBF00, 16'hE400, 16'hFF00, 16'hF700
	};

	localparam string FIELD_NAMES [8] = '{
		"thousands_first_byte", "thousands_second_byte",
		"hundreds_first_byte",  "hundreds_second_byte",
		"tens_first_byte",      "tens_second_byte",
		"ones_first_byte",      "ones_second_byte"
	};

	// frame typed in where it is obvious, otherwise taken from predict_frame
	localparam directed_row_t DIRECTED [25] = '{
		'{16'd0,     1'b1, 64'h0000_0000_0000_FC28},
		'{16'd1,     1'b1, 64'h0000_0000_0000_6020},
		'{16'd9999,  1'b1, 64'hF700_F700_F700_F700},
		'{16'd10000, 1'b1, 64'h0000_0000_0000_FC28},
		'{16'd60000, 1'b1, 64'h0000_0000_0000_FC28},
		'{16'd65535, 1'b1, 64'hB700_B700_F300_B700},
		'{16'd1000,  1'b1, 64'h6020_FC28_FC28_FC28},
		'{16'd2,     1'b0, 64'h0},
		'{16'd3,     1'b0, 64'h0},
		'{16'd4,     1'b0, 64'h0},
		'{16'd5,     1'b0, 64'h0},
		'{16'd6,     1'b0, 64'h0},
		'{16'd7,     1'b0, 64'h0},
		'{16'd8,     1'b0, 64'h0},
		'{16'd9,     1'b0, 64'h0},
		'{16'd10,    1'b0, 64'h0},
		'{16'd99,    1'b0, 64'h0},
		'{16'd100,   1'b0, 64'h0},
		'{16'd1001,  1'b0, 64'h0},
		'{16'd1234,  1'b0, 64'h0},
		'{16'd5678,  1'b0, 64'h0},
		'{16'd9090,  1'b0, 64'h0},
		'{16'd32768, 1'b0, 64'h0},
		'{16'd21845, 1'b0, 64'h0},
		'{16'd43690, 1'b0, 64'h0}
	};

	logic clk;
	logic arst_n;

	nlcd_value_if value_ch ();
	nlcd_seg_if   seg_ch ();

	number_to_lcd_segments dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.value_ch (value_ch),
		.seg_ch   (seg_ch)
	);

	lcd_frame_t frames_due [$];
	value_t     values_due [$];
	int         mismatches   = 0;
	int         src_idle_pct = 0;
	int         snk_idle_pct = 0;
	int         hold_off_req = 0;
	int         hold_off_ack = 0;
	int         hold_left    = 0;

	always begin
		clk = 1'b0;
		#(CLK_PERIOD / 2);
		clk = 1'b1;
		#(CLK_PERIOD / 2);
	end

	// packed BCD sum of two four-digit numbers plus a carry in; top carry lost
	function automatic bcd_t bcd_sum(bcd_t a, bcd_t b, logic cin);
		bcd_t             s;
		logic [DIGIT_W:0] d;
		logic             c;
		s = '0;
		c = cin;
		for (int k = 0; k < DIGITS; k++) begin
			d = {1'b0, a[k*DIGIT_W +: DIGIT_W]} + {1'b0, b[k*DIGIT_W +: DIGIT_W]}
				+ {{DIGIT_W{1'b0}}, c};
			if (d >= 10) begin
				d = d - 5'd10;
				c = 1'b1;
			end else begin
				c = 1'b0;
			end
			s[k*DIGIT_W +: DIGIT_W] = d[DIGIT_W-1:0];
		end
		return s;
	endfunction

	function automatic lcd_frame_t predict_frame(value_t v);
		bcd_t        acc;
		digit_t      d;
		logic        lit;
		logic [63:0] bytes;
		acc = '0;
		for (int k = VALUE_W - 1; k >= 0; k--)
			acc = bcd_sum(acc, acc, v[k]);
		lit   = 1'b0;
		bytes = '0;
		for (int p = 0; p < DIGITS; p++) begin
			d = acc[BCD_W-1-DIGIT_W*p -: DIGIT_W];
			// leading zeros blank; ones digit always lit
			if (d != 0 || p == DIGITS - 1)
				lit = 1'b1;
			if (lit)
				bytes[63-16*p -: 16] = DIGIT_GLYPH[d];
		end
		return lcd_frame_t'(bytes);
	endfunction

	function automatic value_t pick_value();
		value_t v;
		case ($urandom_range(4))
			0: v = value_t'($urandom);
			1: v = value_t'($urandom_range(99));
			2: v = value_t'($urandom_range(9999));
			3: v = value_t'(10000 * $urandom_range(6) + $urandom_range(999));
			default: begin
				// sparse digits to exercise zeros inside and ahead of the number
				v = '0;
				for (int p = 0; p < DIGITS; p++)
					v = value_t'(v * 10 + ($urandom_range(1) ? $urandom_range(9) : 0));
			end
		endcase
		return v;
	endfunction

	task automatic offer(input value_t v, input lcd_frame_t want);
		while ($urandom_range(99) < src_idle_pct) begin
			value_ch.valid <= 1'b0;
			@(posedge clk);
		end
		value_ch.valid <= 1'b1;
		value_ch.value <= v;
		do @(posedge clk); while (!value_ch.ready);
		frames_due.push_back(want);
		values_due.push_back(v);
	endtask

	task automatic drain();
		value_ch.valid <= 1'b0;
		do @(posedge clk); while (frames_due.size() != 0);
	endtask

	task automatic run_random(input int count, input int src_pct, input int snk_pct);
		value_t v;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		repeat (count) begin
			v = pick_value();
			offer(v, predict_frame(v));
		end
	endtask

	always @(posedge clk) begin
		if (hold_off_req != hold_off_ack) begin
			hold_off_ack = hold_off_req;
			hold_left    = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			seg_ch.ready <= 1'b0;
		end else begin
			seg_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	always @(posedge clk) begin : result_check
		lcd_frame_t got;
		lcd_frame_t want;
		value_t     shown;
		logic       bad;
		if (arst_n && seg_ch.valid && seg_ch.ready) begin
			got = {seg_ch.thousands_first_byte, seg_ch.thousands_second_byte,
				seg_ch.hundreds_first_byte, seg_ch.hundreds_second_byte,
				seg_ch.tens_first_byte, seg_ch.tens_second_byte,
				seg_ch.ones_first_byte, seg_ch.ones_second_byte};
			if (frames_due.size() == 0) begin
				if (mismatches < REPORT_LIMIT)
					$display("%0t: transaction with nothing pending, got %h", $time, got);
				mismatches++;
			end else begin
				want  = frames_due.pop_front();
				shown = values_due.pop_front();
				bad   = 1'b0;
				for (int f = 0; f < 8; f++) begin
					if (got[63-8*f -: 8] !== want[63-8*f -: 8]) begin
						if (mismatches < REPORT_LIMIT)
							$display("%0t: value %0d %s expected %h got %h", $time, shown,
								FIELD_NAMES[f], want[63-8*f -: 8], got[63-8*f -: 8]);
						bad = 1'b1;
					end
				end
				if (bad)
					mismatches++;
			end
		end
	end

	initial begin : stimulus
		value_t v;
		arst_n         = 1'b0;
		value_ch.valid = 1'b0;
		value_ch.value = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			v = DIRECTED[i].value;
			offer(v, DIRECTED[i].typed ? lcd_frame_t'(DIRECTED[i].frame) : predict_frame(v));
		end

		run_random(400, 38, 48);
		run_random(400, 48, 38);
		drain();

		// sink stalls while the source keeps pushing, so the pipe fills and
		// value_ch.ready has to drop
		src_idle_pct = 0;
		snk_idle_pct = 0;
		hold_off_req <= hold_off_req + 1;
		repeat (40) begin
			v = pick_value();
			offer(v, predict_frame(v));
		end
		drain();

		run_random(400, 0, 0);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0 && frames_due.size() == 0)
			$display("number_to_lcd_segments verification clean");
		else
			$display("number_to_lcd_segments verification failed");
		$finish;
	end

	initial begin : watchdog
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("number_to_lcd_segments verification failed");
		$finish;
	end

endmodule
